[design/assert_macros.svh]
// Assertion macros shared by the text console design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TCCE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define TCCE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

[design/tcce_pkg.sv]
// Shared constants and controller/datapath interface types of the text console.
`default_nettype none

package tcce_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned OFS_W   = 11;
  localparam int unsigned LIN_W   = 12;

  localparam logic [CMD_W-1:0] CMD_STREAM     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLR_ROW    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLR_SCREEN = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd5;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h0F;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic sweep_step;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic tab_more;
    logic read_wait;
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[design/tcce_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tcce_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/tcce_ctrl.sv]
// Controller state machine that sequences each request through the datapath.
`default_nettype none

`include "assert_macros.svh"

module tcce_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tcce_pkg::dp_sts_t   sts,
  output tcce_pkg::ctl_cmd_t       cmd
);

  import tcce_pkg::*;

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_INIT: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_sweep) begin
          state_nxt = S_SWEEP;
        end else if (sts.tab_more) begin
          state_nxt = S_EXEC;
        end else if (sts.read_wait) begin
          state_nxt = S_DONE;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `TCCE_ASSERT_IMP(a_load_when_free, cmd.out_load, sts.out_free)

endmodule

`default_nettype wire

[design/tcce_dp.sv]
// Datapath: request registers, cursor, screen store sweeps and the result register.
`default_nettype none

`include "assert_macros.svh"

module tcce_dp #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [tcce_pkg::COLOR_W-1:0]        cfg_wdata,
  input  wire logic [tcce_pkg::CMD_W-1:0]          in_command,
  input  wire logic [tcce_pkg::CHAR_W-1:0]         in_char_code,
  input  wire logic [tcce_pkg::COLOR_W-1:0]        in_cell_color,
  input  wire logic [tcce_pkg::COL_W-1:0]          in_target_col,
  input  wire logic [tcce_pkg::ROW_W-1:0]          in_target_row,
  input  wire logic                                out_stall,
  output logic                                     out_valid,
  output logic      [tcce_pkg::COL_W-1:0]          out_cursor_column_now,
  output logic      [tcce_pkg::ROW_W-1:0]          out_cursor_row_now,
  output logic      [tcce_pkg::OFS_W-1:0]          out_cursor_offset,
  output logic      [tcce_pkg::CELL_W-1:0]         out_cell_read,
  input  wire tcce_pkg::ctl_cmd_t                  cmd,
  output tcce_pkg::dp_sts_t                        sts
);

  import tcce_pkg::*;

  localparam int unsigned CELLS    = COLUMNS * ROWS;
  localparam int unsigned AW       = $clog2(CELLS);
  localparam int unsigned COL_SPAN = 2 ** COL_W;

  localparam logic [AW-1:0]    LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0]    COPY_END   = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0]    ROW_STEP   = AW'(COLUMNS);
  localparam logic [AW-1:0]    ROW_SPAN   = AW'(COLUMNS - 1);
  localparam logic [COL_W-1:0] COL_MAX    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_MAX    = ROW_W'(ROWS - 1);
  localparam logic [LIN_W-1:0] COLS_L     = LIN_W'(COLUMNS);

  typedef enum logic [1:0] {
    WA_CUR = 2'd0,
    WA_NXT = 2'd1,
    WA_TGT = 2'd2
  } wa_sel_t;

  // Columns that sit on a tab stop.
  logic [COL_SPAN-1:0] tab_hit;
  for (genvar g = 0; g < COL_SPAN; g++) begin : g_tab
    localparam bit HIT = ((g % TAB_STOP) == 0);
    assign tab_hit[g] = HIT;
  end

  logic [COLOR_W-1:0] text_color_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [CHAR_W-1:0]  ch_r;
  logic [COLOR_W-1:0] color_r;
  logic [COL_W-1:0]   tcol_r;
  logic [ROW_W-1:0]   trow_r;
  logic [COL_W-1:0]   cur_col_r, cur_col_nxt, dec_col;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt, dec_row;
  logic [AW-1:0]      sweep_r, sweep_last_r;
  logic               scroll_r;
  logic [COLOR_W-1:0] blank_color_r;
  logic               wst_vld_r, wst_copy_r;
  logic [AW-1:0]      wst_addr_r;
  logic               out_valid_r;
  logic [COL_W-1:0]   out_col_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [OFS_W-1:0]   out_ofs_r;
  logic [CELL_W-1:0]  out_cell_r;

  logic [LIN_W-1:0]   cur_lin, nxt_lin, trow_base, tgt_lin, ex_lin;
  logic               in_range, at_end_col, at_last_row;
  logic [COL_W-1:0]   col_inc;
  logic               ex_we, rd_ex, need_sweep, tab_more, read_wait, sw_scroll;
  wa_sel_t            wa_sel;
  logic [CELL_W-1:0]  ex_wdata;
  logic [AW-1:0]      sw_start, sw_last;
  logic               sw_rd;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [CELL_W-1:0]  mem_wdata, mem_rdata;

  assign cur_lin     = LIN_W'(cur_row_r) * COLS_L + LIN_W'(cur_col_r);
  assign nxt_lin     = LIN_W'(cur_row_nxt) * COLS_L + LIN_W'(cur_col_nxt);
  assign trow_base   = LIN_W'(trow_r) * COLS_L;
  assign tgt_lin     = trow_base + LIN_W'(tcol_r);
  assign in_range    = (tcol_r <= COL_MAX) && (trow_r <= ROW_MAX);
  assign at_end_col  = (cur_col_r == COL_MAX);
  assign at_last_row = (cur_row_r == ROW_MAX);
  assign col_inc     = cur_col_r + 1'b1;

  always_comb begin
    dec_col    = cur_col_r;
    dec_row    = cur_row_r;
    ex_we      = 1'b0;
    wa_sel     = WA_CUR;
    ex_wdata   = {text_color_r, ch_r};
    rd_ex      = 1'b0;
    need_sweep = 1'b0;
    tab_more   = 1'b0;
    read_wait  = 1'b0;
    sw_start   = '0;
    sw_last    = LAST_CELL;
    sw_scroll  = 1'b0;
    case (cmd_r)
      CMD_STREAM: begin
        if (ch_r == CH_NEWLINE) begin
          dec_col = '0;
          if (at_last_row) begin
            need_sweep = 1'b1;
            sw_scroll  = 1'b1;
          end else begin
            dec_row = cur_row_r + 1'b1;
          end
        end else if (ch_r == CH_BACKSPACE) begin
          if (cur_col_r != '0) begin
            dec_col = cur_col_r - 1'b1;
          end else if (cur_row_r != '0) begin
            dec_row = cur_row_r - 1'b1;
            dec_col = COL_MAX;
          end
          ex_we    = 1'b1;
          wa_sel   = WA_NXT;
          ex_wdata = {text_color_r, CH_BLANK};
        end else begin
          ex_we    = 1'b1;
          ex_wdata = {text_color_r, (ch_r == CH_TAB) ? CH_BLANK : ch_r};
          if (at_end_col) begin
            dec_col = '0;
            if (at_last_row) begin
              need_sweep = 1'b1;
              sw_scroll  = 1'b1;
            end else begin
              dec_row = cur_row_r + 1'b1;
            end
          end else begin
            dec_col  = col_inc;
            tab_more = (ch_r == CH_TAB) && !tab_hit[col_inc];
          end
        end
      end
      CMD_WRITE: begin
        ex_we    = in_range;
        wa_sel   = WA_TGT;
        ex_wdata = {color_r, ch_r};
      end
      CMD_MOVE: begin
        dec_col = (tcol_r > COL_MAX) ? COL_MAX : tcol_r;
        dec_row = (trow_r > ROW_MAX) ? ROW_MAX : trow_r;
      end
      CMD_CLR_ROW: begin
        need_sweep = (trow_r <= ROW_MAX);
        sw_start   = trow_base[AW-1:0];
        sw_last    = trow_base[AW-1:0] + ROW_SPAN;
      end
      CMD_CLR_SCREEN: begin
        dec_col    = '0;
        dec_row    = '0;
        need_sweep = 1'b1;
      end
      CMD_READ: begin
        read_wait = 1'b1;
        rd_ex     = in_range;
      end
      default: begin
      end
    endcase
  end

  assign cur_col_nxt = cmd.exec ? dec_col : cur_col_r;
  assign cur_row_nxt = cmd.exec ? dec_row : cur_row_r;

  always_comb begin
    case (wa_sel)
      WA_CUR:  ex_lin = cur_lin;
      WA_NXT:  ex_lin = nxt_lin;
      WA_TGT:  ex_lin = tgt_lin;
      default: ex_lin = cur_lin;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= RESET_COLOR;
    end else if (cfg_we) begin
      text_color_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r   <= in_command;
      ch_r    <= in_char_code;
      color_r <= in_cell_color;
      tcol_r  <= in_target_col;
      trow_r  <= in_target_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
    end else begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
    end
  end

  // Sweep engine: one cell per step; scroll copies read one row ahead.
  assign sw_rd     = cmd.sweep_step && scroll_r && (sweep_r < COPY_END);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r       <= '0;
      sweep_last_r  <= LAST_CELL;
      scroll_r      <= 1'b0;
      blank_color_r <= RESET_COLOR;
      wst_vld_r     <= 1'b0;
    end else begin
      if (cmd.exec && need_sweep) begin
        sweep_r       <= sw_start;
        sweep_last_r  <= sw_last;
        scroll_r      <= sw_scroll;
        blank_color_r <= text_color_r;
      end else if (cmd.sweep_step) begin
        sweep_r <= sweep_r + 1'b1;
      end
      wst_vld_r <= cmd.sweep_step;
    end
  end

  always_ff @(posedge clk) begin
    wst_addr_r <= sweep_r;
    wst_copy_r <= sw_rd;
  end

  assign mem_we    = wst_vld_r || (cmd.exec && ex_we);
  assign mem_waddr = wst_vld_r ? wst_addr_r : ex_lin[AW-1:0];
  assign mem_wdata = wst_vld_r ? (wst_copy_r ? mem_rdata : {blank_color_r, CH_BLANK})
                               : ex_wdata;
  assign mem_re    = sw_rd || (cmd.exec && rd_ex);
  assign mem_raddr = sw_rd ? (sweep_r + ROW_STEP) : tgt_lin[AW-1:0];

  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (mem_wdata),
    .rd_en     (mem_re),
    .rd_addr   (mem_raddr),
    .rd_data_r (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_col_r  <= cur_col_nxt;
      out_row_r  <= cur_row_nxt;
      out_ofs_r  <= nxt_lin[OFS_W-1:0];
      out_cell_r <= ((cmd_r == CMD_READ) && in_range) ? mem_rdata : '0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_cursor_column_now = out_col_r;
  assign out_cursor_row_now    = out_row_r;
  assign out_cursor_offset     = out_ofs_r;
  assign out_cell_read         = out_cell_r;

  assign sts.need_sweep = need_sweep;
  assign sts.tab_more   = tab_more;
  assign sts.read_wait  = read_wait;
  assign sts.sweep_last = (sweep_r == sweep_last_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  `TCCE_ASSERT_IMP(a_cursor_range, 1'b1, (cur_col_r <= COL_MAX) && (cur_row_r <= ROW_MAX))
  `TCCE_ASSERT_IMP(a_write_port_free, wst_vld_r, !(cmd.exec && ex_we))
  `TCCE_ASSERT_IMP(a_read_in_store, mem_re, mem_raddr <= LAST_CELL)
  `TCCE_ASSERT_NXT(a_copy_aligned, sw_rd, wst_vld_r && wst_copy_r)

endmodule

`default_nettype wire

[design/text_console_cell_engine.sv]
// Top level of the text console cell engine: controller, datapath and screen store.
// Requests arrive on the in_ channel (valid/stall) and each produces exactly one
// result on the out_ channel: the cursor after the request, its linear offset and,
// for a read-cell request, the stored cell. cfg_we writes the current text color.
// A plain character, backspace, direct write or cursor move loads the output register
// in the execute state, or in the done state if that register is still held. A
// read-cell request always goes through the done state, as the screen store read
// port is registered. A tab writes one space per pass through the execute state.
// Clearing a row walks the store one cell a cycle over its COLUMNS cells; clearing
// the screen or a scroll walks all COLUMNS * ROWS cells.
// After reset the store is cleared to blanks in color 0x0F by a pass over all
// COLUMNS * ROWS cells; in_stall stays high during it while color writes are still
// taken. While the receiver stalls, a finished result waits in the output register
// and one more request is accepted and processed; then in_stall stays high until
// the waiting result is taken.
`default_nettype none

module text_console_cell_engine #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [tcce_pkg::COLOR_W-1:0]  cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tcce_pkg::CMD_W-1:0]    in_command,
  input  wire logic [tcce_pkg::CHAR_W-1:0]   in_char_code,
  input  wire logic [tcce_pkg::COLOR_W-1:0]  in_cell_color,
  input  wire logic [tcce_pkg::COL_W-1:0]    in_target_col,
  input  wire logic [tcce_pkg::ROW_W-1:0]    in_target_row,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [tcce_pkg::COL_W-1:0]    out_cursor_column_now,
  output logic      [tcce_pkg::ROW_W-1:0]    out_cursor_row_now,
  output logic      [tcce_pkg::OFS_W-1:0]    out_cursor_offset,
  output logic      [tcce_pkg::CELL_W-1:0]   out_cell_read
);

  import tcce_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (ctl_cmd)
  );

  tcce_dp #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_command            (in_command),
    .in_char_code          (in_char_code),
    .in_cell_color         (in_cell_color),
    .in_target_col         (in_target_col),
    .in_target_row         (in_target_row),
    .out_stall             (out_stall),
    .out_valid             (out_valid),
    .out_cursor_column_now (out_cursor_column_now),
    .out_cursor_row_now    (out_cursor_row_now),
    .out_cursor_offset     (out_cursor_offset),
    .out_cell_read         (out_cell_read),
    .cmd                   (ctl_cmd),
    .sts                   (dp_sts)
  );

endmodule

`default_nettype wire

[tb/console_checker.sv]
// Checker for the text console cell engine: predicts every request's result and compares.
module console_checker #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [tcce_pkg::COLOR_W-1:0] cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [tcce_pkg::CMD_W-1:0]   in_command,
  input  logic [tcce_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcce_pkg::COLOR_W-1:0] in_cell_color,
  input  logic [tcce_pkg::COL_W-1:0]   in_target_col,
  input  logic [tcce_pkg::ROW_W-1:0]   in_target_row,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [tcce_pkg::COL_W-1:0]   out_cursor_column_now,
  input  logic [tcce_pkg::ROW_W-1:0]   out_cursor_row_now,
  input  logic [tcce_pkg::OFS_W-1:0]   out_cursor_offset,
  input  logic [tcce_pkg::CELL_W-1:0]  out_cell_read,
  output int                           outstanding,
  output int                           failures
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcce_pkg::*;

  localparam int unsigned CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [OFS_W-1:0]  ofs;
    logic [CELL_W-1:0] data;
  } cursor_report_t;

  logic [CELL_W-1:0]  screen [CELLS];
  int unsigned        cur_row;
  int unsigned        cur_col;
  logic [COLOR_W-1:0] pen;
  cursor_report_t     awaited [$];

  task automatic blank_row(input int unsigned r);
    for (int unsigned x = 0; x < COLUMNS; x++) begin
      screen[r * COLUMNS + x] = {pen, CH_BLANK};
    end
  endtask

  task automatic feed_line();
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int unsigned i = 0; i + COLUMNS < CELLS; i++) begin
        screen[i] = screen[i + COLUMNS];
      end
      blank_row(ROWS - 1);
      cur_row = ROWS - 1;
    end
  endtask

  task automatic place_glyph(input logic [CHAR_W-1:0] ch);
    screen[cur_row * COLUMNS + cur_col] = {pen, ch};
    cur_col++;
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      feed_line();
    end
  endtask

  task automatic home_and_wipe();
    for (int unsigned r = 0; r < ROWS; r++) begin
      blank_row(r);
    end
    cur_row = 0;
    cur_col = 0;
  endtask

  task automatic predict(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                         input logic [COLOR_W-1:0] color, input logic [COL_W-1:0] col,
                         input logic [ROW_W-1:0] row, output cursor_report_t rep);
    logic              on_screen;
    logic [CELL_W-1:0] fetched;
    int unsigned       lin;
    on_screen = (col < COLUMNS) && (row < ROWS);
    fetched = '0;
    case (cmd)
      CMD_STREAM: begin
        if (ch == CH_NEWLINE) begin
          cur_col = 0;
          feed_line();
        end else if (ch == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
          end else if (cur_row > 0) begin
            cur_row--;
            cur_col = COLUMNS - 1;
          end
          screen[cur_row * COLUMNS + cur_col] = {pen, CH_BLANK};
        end else if (ch == CH_TAB) begin
          do begin
            place_glyph(CH_BLANK);
          end while (cur_col % TAB_STOP != 0);
        end else begin
          place_glyph(ch);
        end
      end
      CMD_WRITE: begin
        if (on_screen) screen[row * COLUMNS + col] = {color, ch};
      end
      CMD_MOVE: begin
        cur_col = (col >= COLUMNS) ? COLUMNS - 1 : col;
        cur_row = (row >= ROWS) ? ROWS - 1 : row;
      end
      CMD_CLR_ROW: begin
        if (row < ROWS) blank_row(row);
      end
      CMD_CLR_SCREEN: begin
        home_and_wipe();
      end
      CMD_READ: begin
        if (on_screen) fetched = screen[row * COLUMNS + col];
      end
      default: begin
      end
    endcase
    lin = cur_row * COLUMNS + cur_col;
    rep.col = cur_col[COL_W-1:0];
    rep.row = cur_row[ROW_W-1:0];
    rep.ofs = lin[OFS_W-1:0];
    rep.data = fetched;
  endtask

  always @(posedge clk) begin : watch
    cursor_report_t got;
    cursor_report_t want;
    if (!rst_n) begin
      pen = RESET_COLOR;
      home_and_wipe();
      awaited.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_cursor_column_now, out_cursor_row_now, out_cursor_offset, out_cell_read};
        if (awaited.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: result with no request pending: col %0d row %0d offset %0d cell %h",
                     $realtime, got.col, got.row, got.ofs, got.data);
          end
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: mismatch: expected col %0d row %0d offset %0d cell %h",
                       $realtime, want.col, want.row, want.ofs, want.data);
              $display("%0t: mismatch: actual   col %0d row %0d offset %0d cell %h",
                       $realtime, got.col, got.row, got.ofs, got.data);
            end
          end
        end
      end
      if (cfg_we) pen = cfg_wdata;
      if (in_valid && !in_stall) begin
        predict(in_command, in_char_code, in_cell_color, in_target_col, in_target_row, want);
        awaited.push_back(want);
      end
      outstanding <= awaited.size();
    end
  end

endmodule

[tb/tb.sv]
// Testbench top for the text console cell engine: request stimulus, result stalls and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcce_pkg::*;

  localparam int unsigned COLUMNS  = 80;
  localparam int unsigned ROWS     = 25;
  localparam int unsigned TAB_STOP = 4;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 2100;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 250;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [COLOR_W-1:0] cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [CMD_W-1:0]   in_command;
  logic [CHAR_W-1:0]  in_char_code;
  logic [COLOR_W-1:0] in_cell_color;
  logic [COL_W-1:0]   in_target_col;
  logic [ROW_W-1:0]   in_target_row;
  logic               out_valid;
  logic               out_stall;
  logic [COL_W-1:0]   out_cursor_column_now;
  logic [ROW_W-1:0]   out_cursor_row_now;
  logic [OFS_W-1:0]   out_cursor_offset;
  logic [CELL_W-1:0]  out_cell_read;
  int                 outstanding;
  int                 failures;

  int hold_reqs;
  int holds_done;
  int burst_left;
  int sent;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  text_console_cell_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) dut (.*);

  console_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) check (.*);

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                              input logic [COLOR_W-1:0] color, input logic [COL_W-1:0] col,
                              input logic [ROW_W-1:0] row);
    int gap;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_char_code <= ch;
    in_cell_color <= color;
    in_target_col <= col;
    in_target_row <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic await_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic load_text_color(input logic [COLOR_W-1:0] color);
    cfg_wdata <= color;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int phase, first, len, k, r, c, kind, pick;
    logic [CHAR_W-1:0] glyph;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_command <= CMD_STREAM;
    in_char_code <= '0;
    in_cell_color <= '0;
    in_target_col <= '0;
    in_target_row <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // The first read also waits out the clearing pass that follows reset.
    send_request(CMD_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    await_quiet();
    load_text_color(8'hFF);
    send_request(CMD_STREAM, 8'h41, 8'h00, 7'd0, 5'd0);
    send_request(CMD_STREAM, 8'hFF, 8'h00, 7'd0, 5'd0);
    send_request(CMD_STREAM, 8'h00, 8'h00, 7'd0, 5'd0);
    send_request(CMD_STREAM, CH_TAB, 8'h00, 7'd0, 5'd0);
    send_request(CMD_STREAM, CH_TAB, 8'h00, 7'd0, 5'd0);
    send_request(CMD_STREAM, CH_BACKSPACE, 8'h00, 7'd0, 5'd0);
    send_request(CMD_MOVE, 8'h00, 8'h00, 7'd0, 5'd0);
    send_request(CMD_STREAM, CH_BACKSPACE, 8'h00, 7'd0, 5'd0);
    send_request(CMD_WRITE, 8'hFF, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 1));
    send_request(CMD_WRITE, 8'h55, 8'hAA, 7'h7F, 5'h1F);
    send_request(CMD_READ, 8'h00, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 1));
    send_request(CMD_READ, 8'h00, 8'h00, 7'h7F, 5'h1F);
    send_request(CMD_MOVE, 8'h00, 8'h00, 7'h7F, 5'h1F);
    send_request(CMD_STREAM, 8'h5A, 8'h00, 7'd0, 5'd0);
    send_request(CMD_READ, 8'h00, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 2));
    send_request(CMD_MOVE, 8'h00, 8'h00, 7'(COLUMNS - 2), 5'(ROWS - 1));
    send_request(CMD_STREAM, CH_TAB, 8'h00, 7'd0, 5'd0);
    send_request(CMD_STREAM, CH_NEWLINE, 8'h00, 7'd0, 5'd0);
    send_request(CMD_MOVE, 8'h00, 8'h00, 7'd0, 5'd5);
    send_request(CMD_STREAM, CH_BACKSPACE, 8'h00, 7'd0, 5'd0);
    send_request(CMD_CLR_ROW, 8'h00, 8'h00, 7'd0, 5'd4);
    send_request(CMD_CLR_ROW, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
    send_request(CMD_SPARE_A, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
    send_request(CMD_SPARE_B, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
    send_request(CMD_CLR_SCREEN, 8'h00, 8'h00, 7'd0, 5'd0);
    send_request(CMD_READ, 8'h00, 8'h00, 7'(COLUMNS - 1), 5'd4);

    for (phase = 0; phase < PHASES; phase++) begin
      await_quiet();
      case (phase)
        0:       load_text_color(8'h00);
        2:       load_text_color(8'hFF);
        default: load_text_color(8'($urandom));
      endcase
      // The receiver holds off while requests keep coming, so the block backs up.
      if (phase % 2 == 1) hold_reqs++;
      first = sent;
      while (sent - first < PHASE_ITEMS) begin
        kind = $urandom_range(0, 99);
        r = $urandom_range(0, ROWS - 1);
        c = $urandom_range(0, COLUMNS - 1);
        if (kind < 65) begin
          send_request(CMD_MOVE, 8'($urandom), 8'($urandom),
                       ($urandom_range(0, 9) == 0) ? 7'($urandom_range(COLUMNS, 127)) : 7'(c),
                       ($urandom_range(0, 9) == 0) ? 5'($urandom_range(ROWS, 31)) : 5'(r));
          len = $urandom_range(4, 30);
          for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) glyph = CH_NEWLINE;
            else if (pick < 13) glyph = CH_BACKSPACE;
            else if (pick < 19) glyph = CH_TAB;
            else glyph = 8'($urandom);
            send_request(CMD_STREAM, glyph, 8'($urandom), 7'($urandom), 5'($urandom));
          end
          len = $urandom_range(1, 3);
          for (k = 0; k < len; k++) begin
            pick = r + $urandom_range(0, 2) - 1;
            if (pick < 0) pick = 0;
            if (pick > ROWS - 1) pick = ROWS - 1;
            send_request(CMD_READ, 8'($urandom), 8'($urandom),
                         7'($urandom_range(0, COLUMNS - 1)), 5'(pick));
          end
        end else if (kind < 82) begin
          if ($urandom_range(0, 7) == 0) c = $urandom_range(0, 127);
          if ($urandom_range(0, 7) == 0) r = $urandom_range(0, 31);
          send_request(CMD_WRITE, 8'($urandom), 8'($urandom), 7'(c), 5'(r));
          send_request(CMD_READ, 8'($urandom), 8'($urandom), 7'(c), 5'(r));
        end else if (kind < 92) begin
          r = $urandom_range(0, 31);
          send_request(CMD_CLR_ROW, 8'($urandom), 8'($urandom), 7'($urandom), 5'(r));
          send_request(CMD_READ, 8'($urandom), 8'($urandom), 7'(c), 5'(r));
        end else if (kind < 97) begin
          if ($urandom_range(0, 1) == 0) begin
            send_request(($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B,
                         8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
          end else begin
            send_request(CMD_READ, 8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
          end
        end else begin
          send_request(CMD_CLR_SCREEN, 8'($urandom), 8'($urandom), 7'($urandom),
                       5'($urandom));
          send_request(CMD_READ, 8'($urandom), 8'($urandom), 7'(c), 5'(r));
        end
      end
    end

    await_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin : receiver
    int mode, span, k;
    forever begin
      if (hold_reqs != holds_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 200);
        for (k = 0; k < span; k++) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 30);
            2:       out_stall <= ($urandom_range(0, 99) < 70);
            default: out_stall <= (k % 5 < 2);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/tcce_pkg.sv
design/tcce_ram.sv
design/tcce_ctrl.sv
design/tcce_dp.sv
design/text_console_cell_engine.sv
tb/console_checker.sv
tb/tb.sv
